// ===== hdl/ip_port_rule_table_match_assert.svh =====
// Assertion macros for the rule table block.
`ifndef IP_PORT_RULE_TABLE_MATCH_ASSERT_SVH
`define IP_PORT_RULE_TABLE_MATCH_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== hdl/iprt_pkg.sv =====
`default_nettype none
package iprt_pkg;
   typedef enum logic [1:0] {
      MODE_ADD = 2'd0, MODE_DEL = 2'd1, MODE_CLEAR = 2'd2, MODE_CLASSIFY = 2'd3
   } mode_type;
   localparam logic [1:0] KIND_V4 = 2'd0;
   localparam logic [1:0] KIND_V6 = 2'd1;
   localparam logic [1:0] KIND_PORT = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DUP = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;
   localparam logic [2:0] VER_4 = 3'd4;
   localparam logic [2:0] VER_6 = 3'd6;
   typedef enum logic [1:0] {
      S_IDLE, S_SCAN, S_DONE
   } state_type;
   // One stored rule.
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [31:0] mask;
      logic [15:0] port;
      logic        direction;
   } entry_type;
endpackage
`default_nettype wire

// ===== hdl/ip_port_rule_table_match.sv =====
// Rule table match. Each request transfer scans the table one entry per cycle through a
// synchronous memory: each entry is read, then compared with the request, then the scan
// ends and the result is loaded into the response register. One item is processed at a
// time (one read port sets it), so a new request is taken only after the last result is
// loaded; a waiting result holds only the final step. Synchronous active-high reset
// empties the table through the valid bits at once; rule contents are not cleared.
`default_nettype none
module ip_port_rule_table_match #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // mode, rule_kind
   input  wire  [3:0]   req_tuser,
   // pkt_ver, addr_a_hi, addr_a_lo, addr_b_hi, addr_b_lo,
   // net_mask, direction, port_a, port_b, zero fill
   input  wire  [327:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status, hit, rule_count
   output logic [7:0]   rsp_tdata
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   iprt_pkg::state_type state_ff, state_in;
   logic [327:0] req_ff;
   logic [AW:0]  idx_ff, idx_in;
   logic         rd_pend_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CW-1:0] count_ff;
   logic         found_ff, found_in;
   logic [AW-1:0] found_idx_ff;
   logic         free_ok_ff;
   logic [AW-1:0] free_idx_ff;
   logic         rsp_valid_ff;
   logic [7:0]   rsp_ff;
   logic         done_go;

   // Request fields.
   logic [1:0]  f_mode, f_kind;
   logic [2:0]  f_ver;
   logic [63:0] f_ahi, f_alo, f_bhi, f_blo;
   logic [31:0] f_mask;
   logic        f_dir;
   logic [15:0] f_pa, f_pb;
   assign f_mode = req_ff[1:0];
   assign f_kind = req_ff[3:2];
   assign f_ver  = req_ff[6:4];
   assign f_ahi  = req_ff[70:7];
   assign f_alo  = req_ff[134:71];
   assign f_bhi  = req_ff[198:135];
   assign f_blo  = req_ff[262:199];
   assign f_mask = req_ff[294:263];
   assign f_dir  = req_ff[295];
   assign f_pa   = req_ff[311:296];
   assign f_pb   = req_ff[327:312];

   // Key of the request with unused fields at zero.
   iprt_pkg::entry_type key;
   always_comb begin
      key = '0;
      key.kind = f_kind;
      key.direction = f_dir;
      if (f_kind == iprt_pkg::KIND_V4) begin
         key.addr_lo = {32'd0, f_alo[31:0]};
         key.mask = f_mask;
      end else if (f_kind == iprt_pkg::KIND_V6) begin
         key.addr_hi = f_ahi;
         key.addr_lo = f_alo;
      end else begin
         key.port = f_pa;
      end
   end

   logic        wr_en;
   logic [AW-1:0] wr_addr;
   iprt_pkg::entry_type rd_data;

   iprt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(key),
      .rd_addr(idx_ff[AW-1:0]), .rd_data(rd_data)
   );

   // Compare of the entry read last cycle.
   logic e_valid, e_match;
   always_comb begin
      e_valid = valid_ff[rd_idx_ff];
      e_match = 1'b0;
      if (f_mode == iprt_pkg::MODE_CLASSIFY) begin
         unique case (rd_data.kind)
            iprt_pkg::KIND_V4:
               e_match = (f_ver == iprt_pkg::VER_4) &&
                  (rd_data.addr_lo == {32'd0, f_alo[31:0]} ||
                   rd_data.addr_lo == {32'd0, f_blo[31:0]});
            iprt_pkg::KIND_V6:
               e_match = (f_ver == iprt_pkg::VER_6) &&
                  ((rd_data.addr_hi == f_ahi && rd_data.addr_lo == f_alo) ||
                   (rd_data.addr_hi == f_bhi && rd_data.addr_lo == f_blo));
            iprt_pkg::KIND_PORT:
               e_match = rd_data.port == f_pa || rd_data.port == f_pb;
            default: e_match = 1'b0;
         endcase
      end else begin
         e_match = (rd_data == key);
      end
      e_match = e_match && e_valid && rd_pend_ff;
   end

   logic scan_end;
   assign scan_end = (idx_ff == (AW+1)'(TABLE_DEPTH)) && !rd_pend_ff;

   // The final step waits while an earlier result is still held.
   assign done_go = (state_ff == iprt_pkg::S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      found_in = found_ff || e_match;
      req_tready = 1'b0;
      wr_en = 1'b0;
      wr_addr = found_idx_ff;
      unique case (state_ff)
         iprt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            found_in = 1'b0;
            idx_in = '0;
            if (req_tvalid && req_tready) state_in = iprt_pkg::S_SCAN;
         end
         iprt_pkg::S_SCAN: begin
            if (idx_ff != (AW+1)'(TABLE_DEPTH)) idx_in = idx_ff + 1'b1;
            if (scan_end) state_in = iprt_pkg::S_DONE;
         end
         iprt_pkg::S_DONE: begin
            wr_addr = free_idx_ff;
            if (done_go) begin
               state_in = iprt_pkg::S_IDLE;
               wr_en = (f_mode == iprt_pkg::MODE_ADD) && (f_kind != iprt_pkg::KIND_NONE) &&
                       !found_ff && free_ok_ff;
            end
         end
         default: state_in = iprt_pkg::S_IDLE;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iprt_pkg::S_IDLE;
         idx_ff <= '0;
         valid_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rd_pend_ff <= (state_ff == iprt_pkg::S_SCAN) &&
                       (idx_ff != (AW+1)'(TABLE_DEPTH));
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
            if (wr_en) begin
               valid_ff[free_idx_ff] <= 1'b1;
               count_ff <= count_ff + 1'b1;
            end else if (f_mode == iprt_pkg::MODE_DEL && f_kind != iprt_pkg::KIND_NONE &&
                         found_ff) begin
               valid_ff[found_idx_ff] <= 1'b0;
               count_ff <= count_ff - 1'b1;
            end else if (f_mode == iprt_pkg::MODE_CLEAR) begin
               valid_ff <= '0;
               count_ff <= '0;
            end
         end
      end
   end

   // Result value computed from the pre-update count.
   logic [1:0] st;
   logic [CW-1:0] cnt_next;
   always_comb begin
      st = iprt_pkg::ST_OK;
      cnt_next = count_ff;
      unique case (f_mode)
         iprt_pkg::MODE_ADD: begin
            if (f_kind == iprt_pkg::KIND_NONE) st = iprt_pkg::ST_NOTFOUND;
            else if (found_ff) st = iprt_pkg::ST_DUP;
            else if (!free_ok_ff) st = iprt_pkg::ST_FULL;
            else cnt_next = count_ff + 1'b1;
         end
         iprt_pkg::MODE_DEL: begin
            if (f_kind == iprt_pkg::KIND_NONE || !found_ff) st = iprt_pkg::ST_NOTFOUND;
            else cnt_next = count_ff - 1'b1;
         end
         iprt_pkg::MODE_CLEAR: cnt_next = '0;
         default: st = iprt_pkg::ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == iprt_pkg::S_IDLE && req_tvalid && req_tready) begin
         req_ff <= {req_tdata[323:0], req_tuser};
         free_ok_ff <= 1'b0;
         free_idx_ff <= '0;
      end
      rd_idx_ff <= idx_ff[AW-1:0];
      found_ff <= found_in;
      if (e_match && !found_ff) found_idx_ff <= rd_idx_ff;
      if (rd_pend_ff && !e_valid && !free_ok_ff) begin
         free_ok_ff <= 1'b1;
         free_idx_ff <= rd_idx_ff;
      end
      if (done_go) begin
         rsp_ff <= {5'(cnt_next), (f_mode == iprt_pkg::MODE_CLASSIFY) && found_ff, st};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

`include "ip_port_rule_table_match_assert.svh"
   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, state_ff != iprt_pkg::S_IDLE, !req_tready)
   `ASSERT_NEXT(a_done_gives_rsp, clock, reset, state_ff == iprt_pkg::S_DONE, rsp_tvalid)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH))
   `ASSERT_IMPLIES(a_count_match, clock, reset, 1'b1, 32'($countones(valid_ff)) == 32'(count_ff))
endmodule
`default_nettype wire

// ===== hdl/iprt_mem.sv =====
`default_nettype none
// Rule storage: one write port, one read port with registered read data.
module iprt_mem #(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input  wire                  clock,
   input  wire                  wr_en,
   input  wire [AW-1:0]         wr_addr,
   input  iprt_pkg::entry_type  wr_data,
   input  wire [AW-1:0]         rd_addr,
   output iprt_pkg::entry_type  rd_data
);
   iprt_pkg::entry_type mem_array [DEPTH];
   iprt_pkg::entry_type rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== tb/sv/ip_port_rule_table_match_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ip_port_rule_table_match_checker (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [3:0]   req_tuser,
   input  wire  [327:0] req_tdata,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [7:0]   rsp_tdata,
   output int           error_count,
   output int           pending_count
);
   localparam int DEPTH = 16;

   typedef struct packed {
      logic [4:0] rule_count;
      logic       hit;
      logic [1:0] status;
   } verdict_type;

   logic                rule_valid [DEPTH];
   iprt_pkg::entry_type rule_store [DEPTH];
   int                  rules_held;
   verdict_type         verdict_queue [$];
   logic [327:0]        req_word;

   // Request fields in one word, mode and kind in the low bits.
   assign req_word = {req_tdata[323:0], req_tuser};

   // Duplicate-key search over the valid rules; returns -1 when absent.
   function automatic int find_same(iprt_pkg::entry_type key);
      for (int i = 0; i < DEPTH; i++) begin
         if (rule_valid[i] && rule_store[i] == key) return i;
      end
      return -1;
   endfunction

   // Exact-match classification of a packet against every valid rule.
   function automatic logic packet_blocked(logic [327:0] d);
      logic [2:0] ver;
      logic [63:0] ahi, alo, bhi, blo;
      logic [15:0] lport, rport;
      ver = d[6:4];
      ahi = d[70:7];
      alo = d[134:71];
      bhi = d[198:135];
      blo = d[262:199];
      lport = d[311:296];
      rport = d[327:312];
      for (int i = 0; i < DEPTH; i++) begin
         if (!rule_valid[i]) continue;
         case (rule_store[i].kind)
            iprt_pkg::KIND_V4: begin
               if (ver == iprt_pkg::VER_4 &&
                   (rule_store[i].addr_lo == {32'd0, alo[31:0]} ||
                    rule_store[i].addr_lo == {32'd0, blo[31:0]})) return 1'b1;
            end
            iprt_pkg::KIND_V6: begin
               if (ver == iprt_pkg::VER_6 &&
                   ((rule_store[i].addr_hi == ahi && rule_store[i].addr_lo == alo) ||
                    (rule_store[i].addr_hi == bhi && rule_store[i].addr_lo == blo)))
                  return 1'b1;
            end
            iprt_pkg::KIND_PORT: begin
               if (rule_store[i].port == lport || rule_store[i].port == rport)
                  return 1'b1;
            end
            default: ;
         endcase
      end
      return 1'b0;
   endfunction

   // Apply one request to the shadow table and return the expected response.
   function automatic verdict_type apply_request(logic [327:0] d);
      verdict_type v;
      iprt_pkg::entry_type key;
      logic [1:0] md, kind;
      int idx;
      md = d[1:0];
      kind = d[3:2];
      v = '0;
      key = '0;
      key.kind = kind;
      key.direction = d[295];
      if (kind == iprt_pkg::KIND_V4) begin
         key.addr_lo = {32'd0, d[102:71]};
         key.mask = d[294:263];
      end
      if (kind == iprt_pkg::KIND_V6) begin
         key.addr_hi = d[70:7];
         key.addr_lo = d[134:71];
      end
      if (kind == iprt_pkg::KIND_PORT) key.port = d[311:296];
      if (md == iprt_pkg::MODE_ADD || md == iprt_pkg::MODE_DEL) begin
         if (kind > iprt_pkg::KIND_PORT) begin
            v.status = iprt_pkg::ST_NOTFOUND;
         end else begin
            idx = find_same(key);
            if (md == iprt_pkg::MODE_DEL) begin
               if (idx < 0) v.status = iprt_pkg::ST_NOTFOUND;
               else begin
                  rule_valid[idx] = 1'b0;
                  rules_held--;
               end
            end else if (idx >= 0) begin
               v.status = iprt_pkg::ST_DUP;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (!rule_valid[i]) begin
                     idx = i;
                     break;
                  end
               end
               if (idx < 0) v.status = iprt_pkg::ST_FULL;
               else begin
                  rule_valid[idx] = 1'b1;
                  rule_store[idx] = key;
                  rules_held++;
               end
            end
         end
      end else if (md == iprt_pkg::MODE_CLEAR) begin
         for (int i = 0; i < DEPTH; i++) rule_valid[i] = 1'b0;
         rules_held = 0;
      end else begin
         v.hit = packet_blocked(d);
      end
      v.rule_count = rules_held[4:0];
      return v;
   endfunction

   assign pending_count = verdict_queue.size();

   // Predict on each request transfer and compare on each response transfer.
   always @(posedge clock) begin
      verdict_type want, got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) rule_valid[i] = 1'b0;
         rules_held = 0;
         error_count <= 0;
         verdict_queue.delete();
      end else begin
         if (req_tvalid && req_tready) verdict_queue.push_back(apply_request(req_word));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (verdict_queue.size() == 0) begin
               $display("%0t: response with none expected, actual %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               if (want.status != got.status || want.hit != got.hit ||
                   want.rule_count != got.rule_count) begin
                  $display({"%0t: mismatch expected status %0d hit %0d count %0d,",
                            " actual %0d %0d %0d"},
                     $time, want.status, want.hit, want.rule_count,
                     got.status, got.hit, got.rule_count);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/ip_port_rule_table_match_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ip_port_rule_table_match_test;
   localparam int ITEMS = 650;
   localparam int QUIET_LIMIT = 4000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [3:0]   req_tuser = '0;
   logic [327:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   int           error_count, pending_count;
   int           quiet_cycles = 0;
   int           sent = 0;
   bit           calm = 1'b0;

   // Small pools of keys so adds, deletes and hits collide often.
   logic [63:0] addr_pool [4];
   logic [15:0] port_pool [4];

   ip_port_rule_table_match u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   ip_port_rule_table_match_checker u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] pick_addr();
      return ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 3)]
                                         : {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_port();
      return ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 3)]
                                         : 16'($urandom);
   endfunction

   // Pack one request word: mode and kind in the low bits, then the tdata fields.
   function automatic logic [327:0] pack_req(logic [1:0] md, logic [1:0] kind,
      logic [2:0] ver, logic [63:0] ahi, logic [63:0] alo, logic [63:0] bhi,
      logic [63:0] blo, logic [31:0] msk, logic dir, logic [15:0] pa, logic [15:0] pb);
      return {pb, pa, dir, msk, blo, bhi, alo, ahi, ver, kind, md};
   endfunction

   function automatic logic [327:0] random_req();
      logic [1:0] md, kind;
      logic [2:0] ver;
      md = 2'($urandom_range(0, 3));
      kind = ($urandom_range(0, 15) == 0) ? iprt_pkg::KIND_NONE : 2'($urandom_range(0, 2));
      if (md == iprt_pkg::MODE_CLEAR && $urandom_range(0, 7) != 0) md = iprt_pkg::MODE_CLASSIFY;
      ver = ($urandom_range(0, 9) == 0) ? 3'($urandom)
          : ($urandom_range(0, 1) ? iprt_pkg::VER_4 : iprt_pkg::VER_6);
      return pack_req(md, kind, ver, pick_addr(), pick_addr(), pick_addr(), pick_addr(),
         ($urandom_range(0, 1) ? 32'hFFFFFF00 : $urandom), 1'($urandom_range(0, 1)),
         pick_port(), pick_port());
   endfunction

   // Send one request, holding valid until the transfer; valid drops only for a gap.
   task automatic send(logic [327:0] d);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= d[3:0];
      req_tdata <= {4'd0, d[327:4]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // Response side stalls in random bursts.
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Watchdog on cycles with no transfer on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ip_port_rule_table_match_test: errors");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) begin
         addr_pool[i] = {$urandom, $urandom};
         port_pool[i] = 16'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each kind, duplicates, field extremes, hits, misses, full, clear.
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '1, '1, '0, '0, '1, 1'b1, '1, '0));
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, '1, '0, '0, '1, 1'b1, '0, '0));
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, '1, '0, '0, '1, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_V6, iprt_pkg::VER_6,
         '1, '1, '0, '0, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_PORT, iprt_pkg::VER_4,
         '0, '0, '0, '0, '0, 1'b0, 16'hFFFF, '0));
      send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_NONE, iprt_pkg::VER_4,
         '0, '0, '0, '0, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_DEL, iprt_pkg::KIND_NONE, iprt_pkg::VER_4,
         '0, '0, '0, '0, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_CLASSIFY, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, 64'hFFFFFFFF, '0, '0, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_CLASSIFY, iprt_pkg::KIND_V4, iprt_pkg::VER_6,
         '1, '1, '0, '0, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_CLASSIFY, iprt_pkg::KIND_V4, iprt_pkg::VER_6,
         '0, '0, '1, '1, '0, 1'b0, '0, '0));
      send(pack_req(iprt_pkg::MODE_CLASSIFY, iprt_pkg::KIND_V4, 3'd7,
         '0, '0, '0, '0, '0, 1'b0, '0, 16'hFFFF));
      send(pack_req(iprt_pkg::MODE_CLASSIFY, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, '0, '0, '0, '0, 1'b0, 16'h1, 16'h2));
      send(pack_req(iprt_pkg::MODE_DEL, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, 64'hFFFFFFFF, '0, '0, '1, 1'b1, '0, '0));
      send(pack_req(iprt_pkg::MODE_DEL, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, 64'hFFFFFFFF, '0, '0, '1, 1'b1, '0, '0));
      for (int i = 0; i < 15; i++)
         send(pack_req(iprt_pkg::MODE_ADD, iprt_pkg::KIND_PORT, iprt_pkg::VER_4,
            '0, '0, '0, '0, '0, 1'b1, 16'(i), '0));
      send(pack_req(iprt_pkg::MODE_CLEAR, iprt_pkg::KIND_V4, iprt_pkg::VER_4,
         '0, '0, '0, '0, '0, 1'b0, '0, '0));

      // Random traffic, calm in the last stretch.
      while (sent < ITEMS) begin
         if (sent > ITEMS - 40) calm = 1'b1;
         send(random_req());
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d requests: all modes and rule kinds, duplicates, full table,", sent);
      $display("unknown kinds, both IP versions and odd versions, with random stalls.");
      if (error_count == 0) begin
         $display("ip_port_rule_table_match_test: clean");
      end else begin
         $display("ip_port_rule_table_match_test: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
